### src/rfd_pkg.sv
// Shared types and constants of the remote frame decoder.
package rfd_pkg;

  localparam int FRAME_LEN   = 18;
  localparam int POS_W       = 5;
  // Only bytes 0 to 14 feed a result; bytes 15 to 17 are counted, not held.
  localparam int STORE_DEPTH = 15;
  localparam int STORE_IDX_W = 4;
  localparam int CH_W        = 11;
  localparam int SW_W        = 2;
  localparam int AXIS_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int OUT_W       = 120;

  localparam logic [POS_W-1:0] LAST_POS     = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] STORE_LIMIT  = POS_W'(STORE_DEPTH);
  localparam logic [SW_W-1:0]  SW_INVALID   = 2'd0;

  typedef struct packed {
    logic [CH_W-1:0]   stick_ch0;
    logic [CH_W-1:0]   stick_ch1;
    logic [CH_W-1:0]   stick_ch2;
    logic [CH_W-1:0]   stick_ch3;
    logic [SW_W-1:0]   switch_left;
    logic [SW_W-1:0]   switch_right;
    logic [AXIS_W-1:0] mouse_x;
    logic [AXIS_W-1:0] mouse_y;
    logic [AXIS_W-1:0] mouse_z;
    logic [BYTE_W-1:0] mouse_left;
    logic [BYTE_W-1:0] mouse_right;
    logic [BYTE_W-1:0] keys_low;
  } result_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } queue_status_t;

endpackage

### src/rfd_front.sv
// Front end: byte counter, frame byte store, unpack and switch check.
module rfd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [7:0]                in_data,
  output logic                      in_ready,
  input  logic                      queue_ready,
  output logic                      push,
  output rfd_pkg::result_t          rec
);

  logic [rfd_pkg::POS_W-1:0]  pos;
  logic [rfd_pkg::POS_W-1:0]  pos_next;
  logic [7:0]                 store [rfd_pkg::STORE_DEPTH];
  logic                       frame_end;
  logic                       accept;
  logic                       sw_ok;

  // Any count at or past the last position closes the frame.
  assign frame_end = (pos >= rfd_pkg::LAST_POS);
  assign in_ready  = !frame_end || queue_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    pos_next = pos;
    if (accept) begin
      if (frame_end) begin
        pos_next = '0;
      end else begin
        pos_next = pos + rfd_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pos < rfd_pkg::STORE_LIMIT)) begin
      store[pos[rfd_pkg::STORE_IDX_W-1:0]] <= in_data;
    end
  end

  always_comb begin
    rec.stick_ch0    = {store[1][2:0], store[0]};
    rec.stick_ch1    = {store[2][5:0], store[1][7:3]};
    rec.stick_ch2    = {store[4][0], store[3], store[2][7:6]};
    rec.stick_ch3    = {store[5][3:0], store[4][7:1]};
    rec.switch_left  = store[5][7:6];
    rec.switch_right = store[5][5:4];
    rec.mouse_x      = {store[7], store[6]};
    rec.mouse_y      = {store[9], store[8]};
    rec.mouse_z      = {store[11], store[10]};
    rec.mouse_left   = store[12];
    rec.mouse_right  = store[13];
    rec.keys_low     = store[14];
  end

  assign sw_ok = (rec.switch_left != rfd_pkg::SW_INVALID) &&
                 (rec.switch_right != rfd_pkg::SW_INVALID);
  assign push  = accept && frame_end && sw_ok;

endmodule

### src/rfd_fifo.sv
// Short queue of decoded frames between front end and output stage.
module rfd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  rfd_pkg::result_t       push_data,
  input  logic                   pop,
  output rfd_pkg::result_t       head,
  output rfd_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rfd_pkg::result_t   mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign status.not_empty = (count != '0);
  assign status.not_full  = (count != CNT_FULL);
  assign do_push = push && status.not_full;
  assign do_pop  = pop && status.not_empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

### src/rfd_back.sv
// Output stage: registered result and its handshake.
module rfd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          queue_valid,
  input  rfd_pkg::result_t              head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rfd_pkg::OUT_W-1:0]     out_data
);

  assign pop = queue_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= {head.keys_low, head.mouse_right, head.mouse_left,
                   head.mouse_z, head.mouse_y, head.mouse_x,
                   head.switch_right, head.switch_left,
                   head.stick_ch3, head.stick_ch2, head.stick_ch1, head.stick_ch0};
    end
  end

endmodule

### src/remote_frame_decoder_unit.sv
// Top level of the remote frame decoder: front end, frame queue, output stage.
//
// The block takes one received byte per request on the slave side and counts
// it into an 18-byte remote-control frame. Bytes 0 to 14 are held; on the
// 18th byte the frame is unpacked into four 11-bit stick channels, the two
// three-position switches, three 16-bit mouse axes, the two mouse button
// bytes and the low keyboard byte. A frame in which either switch reads 0
// is dropped and gives no result. Framing rests on the byte counter alone:
// there is no resynchronization, so a lost byte shifts every later frame.
// Rate: one byte per cycle, sustained. The only point at which the input can
// stall is the last byte of a frame, and only while the frame queue
// (QUEUE_DEPTH entries) is full because the master side is not taking
// results. A result passes through the frame queue and then the output
// register before it appears on the master side.
module remote_frame_decoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] rx_byte
  output logic          m_tvalid,
  input  logic          m_tready,
  // [10:0] stick_ch0, [21:11] stick_ch1, [32:22] stick_ch2, [43:33] stick_ch3,
  // [45:44] switch_left, [47:46] switch_right, [63:48] mouse_x,
  // [79:64] mouse_y, [95:80] mouse_z, [103:96] mouse_left,
  // [111:104] mouse_right, [119:112] keys_low
  output logic [119:0]  m_tdata
);

  logic                   front_push;
  rfd_pkg::result_t       front_rec;
  rfd_pkg::result_t       q_head;
  rfd_pkg::queue_status_t q_stat;
  logic                   back_pop;

  // Count, hold and unpack; push a record only for frames with valid switches.
  rfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_data     (s_tdata),
    .in_ready    (s_tready),
    .queue_ready (q_stat.not_full),
    .push        (front_push),
    .rec         (front_rec)
  );

  // Hold decoded frames so the byte counter keeps running while results wait.
  rfd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data (front_rec),
    .pop       (back_pop),
    .head      (q_head),
    .status    (q_stat)
  );

  // Advance a record into the output register whenever it is free or drains.
  rfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_valid (q_stat.not_empty),
    .head        (q_head),
    .pop         (back_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (m_tdata)
  );

`ifndef SYNTHESIS
  // A decoded frame is never pushed into a full queue.
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    front_push |-> q_stat.not_full)
    else $error("frame pushed into full queue");

  // The input stalls only because the queue is full.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> !q_stat.not_full)
    else $error("input stalled with room in queue");

  // Nothing is offered on the master side right after reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

  // A pop always moves a record into a free or draining output register.
  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    back_pop |=> m_tvalid)
    else $error("popped record not shown");
`endif

endmodule
